FILE: rtl/rsm_pkg.sv
// Package for the running set median core: sizes and the beat types of both channels.
// Has no dependencies. It is used by the core and by its checker.
package rsm_pkg;

    localparam int CAPACITY   = 64;
    localparam int PRICE_BITS = 24;
    localparam int COUNT_BITS = 7;
    localparam int MEDIAN_W   = PRICE_BITS + 1;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W     = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic signed [PRICE_BITS-1:0] price;
        logic                         last;
    } sample_t;

    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median;
        logic [COUNT_BITS-1:0]      count;
        logic                       overflow;
    } result_t;

endpackage

FILE: rtl/running_set_median_core.sv
// Running set median core: sorted insertion into a store with one read and one write port, then median pick.
// Depends on rsm_pkg for sizes and beat types.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  sample   | in        | sample_valid/_stall  | rsm_pkg::sample_t (price, last)
//  result   | out       | result_valid/_stall  | rsm_pkg::result_t (median, count, overflow)
//
// A sample is compared with the stored entries from the top down, one compare and one
// store access per cycle, each larger entry moving up one place until the sample is
// written; the first sample is written at once and a dropped sample is not stored. A last
// sample then reads the middle entries through the same store port and loads the output register.
// Reset clears the fill count, drop flag and sequencer; the store itself is not cleared.
// A stalled result holds in the output register while the next set streams in.
module running_set_median_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  rsm_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output rsm_pkg::result_t result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_M0   = 3'd3;
    localparam logic [2:0] S_M1   = 3'd4;
    localparam logic [2:0] S_M2   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [rsm_pkg::PRICE_BITS-1:0] mem [rsm_pkg::CAPACITY];

    logic [2:0] state_reg, state_next;
    logic [rsm_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic dropped_reg, dropped_next;
    logic [rsm_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic signed [rsm_pkg::PRICE_BITS-1:0] x_reg, x_next;
    logic last_reg, last_next;
    logic signed [rsm_pkg::PRICE_BITS-1:0] acc_reg, acc_next;
    logic signed [rsm_pkg::MEDIAN_W-1:0] med_reg, med_next;
    logic signed [rsm_pkg::PRICE_BITS-1:0] rdata_reg;
    logic out_valid_reg, out_valid_next;
    rsm_pkg::result_t out_reg, out_next;

    logic wr_en;
    logic [rsm_pkg::ADDR_W-1:0] wr_addr;
    logic [rsm_pkg::PRICE_BITS-1:0] wr_data;
    logic rd_en;
    logic [rsm_pkg::ADDR_W-1:0] rd_addr;
    logic [rsm_pkg::FILL_W-1:0] half;
    logic accept;

    assign accept       = sample_valid && (state_reg == S_IDLE);
    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign half         = fill_reg >> 1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        dropped_next   = dropped_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        med_next       = med_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = x_reg;
        rd_en          = 1'b0;
        rd_addr        = rsm_pkg::ADDR_W'(pos_reg - rsm_pkg::ADDR_W'(2));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next    = sample.price;
                    last_next = sample.last;
                    if (fill_reg == rsm_pkg::FILL_W'(rsm_pkg::CAPACITY))
                    begin
                        dropped_next = 1'b1;
                        state_next   = sample.last ? S_M0 : S_IDLE;
                    end
                    else if (fill_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = sample.price;
                        fill_next  = fill_reg + 1'b1;
                        state_next = sample.last ? S_M0 : S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = rsm_pkg::ADDR_W'(fill_reg - 1'b1);
                        pos_next   = rsm_pkg::ADDR_W'(fill_reg);
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                wr_en = 1'b1;
                if (rdata_reg > x_reg)
                begin
                    wr_data  = rdata_reg;
                    pos_next = pos_reg - 1'b1;
                    if (pos_reg == rsm_pkg::ADDR_W'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                end
                else
                begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = last_reg ? S_M0 : S_IDLE;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                fill_next  = fill_reg + 1'b1;
                state_next = last_reg ? S_M0 : S_IDLE;
            end
            S_M0:
            begin
                rd_en      = 1'b1;
                rd_addr    = fill_reg[0] ? rsm_pkg::ADDR_W'(half)
                                         : rsm_pkg::ADDR_W'(half - 1'b1);
                state_next = S_M1;
            end
            S_M1:
            begin
                acc_next = rdata_reg;
                if (fill_reg[0])
                begin
                    med_next   = {rdata_reg, 1'b0};
                    state_next = S_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rsm_pkg::ADDR_W'(half);
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                med_next   = rsm_pkg::MEDIAN_W'(acc_reg) + rsm_pkg::MEDIAN_W'(rdata_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.median   = med_reg;
                    out_next.count    = rsm_pkg::COUNT_BITS'(fill_reg);
                    out_next.overflow = dropped_reg;
                    out_valid_next    = 1'b1;
                    fill_next         = '0;
                    dropped_next      = 1'b0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        x_reg    <= x_next;
        last_reg <= last_next;
        acc_reg  <= acc_next;
        med_reg  <= med_next;
        out_reg  <= out_next;
    end

endmodule

FILE: rtl/running_set_median_checker.sv
// Port-level checker for the running set median core, bound into every core instance.
// Depends on rsm_pkg for the beat types and capacity.
module running_set_median_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input rsm_pkg::sample_t sample,
    input logic             result_valid,
    input logic             result_stall,
    input rsm_pkg::result_t result
);

    logic sample_beat;

    assign sample_beat = sample_valid && !sample_stall;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_no_result_after_plain: assert property (@(posedge clk) disable iff (!rst_n)
        sample_beat && !sample.last |=> !$rose(result_valid))
        else $error("result raised after a non-final sample");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        sample_beat && sample.last |=> sample_stall)
        else $error("sample taken while median pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.count != '0) &&
                         (result.count <= rsm_pkg::COUNT_BITS'(rsm_pkg::CAPACITY)))
        else $error("result count out of range");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result appeared without median work");

endmodule

bind running_set_median_core running_set_median_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for running_set_median_core: streams sets of samples and
// checks each median beat against a sorted-insertion predictor. Uses rsm_pkg.
module tb_top;

    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_ITEMS = 750;
    localparam logic signed [rsm_pkg::PRICE_BITS-1:0] PRICE_MAX =
        {1'b0, {(rsm_pkg::PRICE_BITS-1){1'b1}}};
    localparam logic signed [rsm_pkg::PRICE_BITS-1:0] PRICE_MIN =
        {1'b1, {(rsm_pkg::PRICE_BITS-1){1'b0}}};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_stall;
    rsm_pkg::sample_t sample = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    rsm_pkg::result_t result;

    rsm_pkg::sample_t pending_samples[$];
    rsm_pkg::result_t expected_medians[$];

    logic signed [rsm_pkg::PRICE_BITS-1:0] kept_prices[rsm_pkg::CAPACITY];
    int  kept_count = 0;
    bit  drop_seen = 1'b0;

    int total_items = 0;
    int accepted_cnt = 0;
    int mismatches = 0;
    int cycles = 0;
    int idle_pct;
    int stall_pct;

    running_set_median_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always_comb
    begin
        unique case ((total_items == 0) ? 0 : (accepted_cnt * 4) / total_items)
            1:       begin idle_pct = 79; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 79; end
            3:       begin idle_pct = 26; stall_pct = 26; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    end

    // Insert one sample into the sorted set and close the set on a last beat.
    task automatic fold_sample(input rsm_pkg::sample_t s);
        int               pos;
        int               half;
        rsm_pkg::result_t r;
        begin
            if (kept_count < rsm_pkg::CAPACITY)
            begin
                pos = kept_count;
                while (pos > 0 && kept_prices[pos-1] > s.price)
                begin
                    kept_prices[pos] = kept_prices[pos-1];
                    pos--;
                end
                kept_prices[pos] = s.price;
                kept_count++;
            end
            else
                drop_seen = 1'b1;
            if (s.last)
            begin
                half = kept_count / 2;
                if (kept_count % 2 == 0)
                    r.median = $signed({kept_prices[half-1][rsm_pkg::PRICE_BITS-1],
                                        kept_prices[half-1]})
                             + $signed({kept_prices[half][rsm_pkg::PRICE_BITS-1],
                                        kept_prices[half]});
                else
                    r.median = {kept_prices[half], 1'b0};
                r.count    = rsm_pkg::COUNT_BITS'(kept_count);
                r.overflow = drop_seen;
                expected_medians = {expected_medians, r};
                kept_count = 0;
                drop_seen  = 1'b0;
            end
        end
    endtask

    task automatic flag_field(input string field, input longint want, input longint got);
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    task automatic add_sample(input logic signed [rsm_pkg::PRICE_BITS-1:0] p,
                              input logic is_last);
        rsm_pkg::sample_t s;
        begin
            s.price = p;
            s.last  = is_last;
            pending_samples = {pending_samples, s};
        end
    endtask

    function automatic logic signed [rsm_pkg::PRICE_BITS-1:0] pick_price(input int flavour);
        logic signed [rsm_pkg::PRICE_BITS-1:0] v;
        begin
            unique case (flavour)
                0:       v = rsm_pkg::PRICE_BITS'($urandom);
                1:       v = rsm_pkg::PRICE_BITS'($urandom_range(1023))
                             - rsm_pkg::PRICE_BITS'(512);
                2:       v = rsm_pkg::PRICE_BITS'($urandom_range(3))
                             * rsm_pkg::PRICE_BITS'(256);
                default: v = $urandom_range(1)
                             ? PRICE_MAX - rsm_pkg::PRICE_BITS'($urandom_range(3))
                             : PRICE_MIN + rsm_pkg::PRICE_BITS'($urandom_range(3));
            endcase
            return v;
        end
    endfunction

    task automatic add_set(input int n);
        int flavour;
        begin
            flavour = $urandom_range(3);
            for (int i = 0; i < n; i++)
                add_sample(pick_price(flavour), i == n - 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else if (!sample_valid || !sample_stall)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                sample_valid <= 1'b1;
                sample       <= pending_samples.pop_front();
            end
            else
                sample_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                accepted_cnt++;
                fold_sample(sample);
            end
            if (result_valid && !result_stall)
            begin
                if (expected_medians.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: median %0d count %0d overflow %0d",
                                 result.median, result.count, result.overflow);
                end
                else
                begin
                    if (result.median !== expected_medians[0].median)
                        flag_field("median", expected_medians[0].median, result.median);
                    if (result.count !== expected_medians[0].count)
                        flag_field("count", expected_medians[0].count, result.count);
                    if (result.overflow !== expected_medians[0].overflow)
                        flag_field("overflow", expected_medians[0].overflow, result.overflow);
                    void'(expected_medians.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        int roll;

        add_sample(PRICE_MAX, 1'b1);
        add_sample(PRICE_MIN, 1'b1);
        add_sample(PRICE_MAX, 1'b0);
        add_sample(PRICE_MAX, 1'b1);
        add_sample(PRICE_MIN, 1'b0);
        add_sample(PRICE_MIN, 1'b1);
        add_sample(PRICE_MIN, 1'b0);
        add_sample(PRICE_MAX, 1'b1);
        add_sample(rsm_pkg::PRICE_BITS'(0), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(0), 1'b1);
        add_sample(rsm_pkg::PRICE_BITS'(5), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(5), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(5), 1'b1);
        add_sample(rsm_pkg::PRICE_BITS'(4), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(3), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(2), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(1), 1'b1);
        add_sample(rsm_pkg::PRICE_BITS'(0), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(-1), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(1), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(7), 1'b0);
        add_sample(rsm_pkg::PRICE_BITS'(-256), 1'b1);

        // Fill the store exactly, then overrun it so the closing beat is dropped.
        add_set(rsm_pkg::CAPACITY);
        add_set(rsm_pkg::CAPACITY + 2);
        n = 2 * rsm_pkg::CAPACITY + 2;
        while (n < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 85)
                add_set($urandom_range(8, 1));
            else if (roll < 95)
                add_set($urandom_range(40, 9));
            else
                add_set($urandom_range(rsm_pkg::CAPACITY + 8, rsm_pkg::CAPACITY - 4));
            n = n + 1;
            n = pending_samples.size() - 22;
        end
        total_items = pending_samples.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_cnt == total_items);
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_medians.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
